// ===== design/dcsm_pkg.sv =====
// Shared types, constants and helper functions for the digital clock block.
// No dependencies; imported by every module of the block.
package dcsm_pkg;

  localparam int unsigned TpsW  = 8;
  localparam int unsigned TickW = 8;
  localparam int unsigned SecW  = 6;
  localparam int unsigned MinW  = 6;
  localparam int unsigned HourW = 5;

  localparam logic [TpsW-1:0] TpsReset = 8'd5;
  localparam logic [5:0]      SecMod   = 6'd60;
  localparam logic [5:0]      MinMod   = 6'd60;
  localparam logic [5:0]      HourMod  = 6'd24;

  typedef enum logic [1:0] {
    EditRun  = 2'd0,
    EditHour = 2'd1,
    EditMin  = 2'd2,
    EditSec  = 2'd3
  } edit_e;

  // Input word: one tick or one button event
  typedef struct packed {
    logic command;
    logic btn_select;
    logic btn_up;
    logic btn_dn;
  } cmd_t;

  // Output word: display digits, edit position, redraw flag
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
    logic [1:0] edit_field;
    logic       refresh;
  } disp_t;

  // Time after an update, handed from the counter core to the digit split
  typedef struct packed {
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    edit_e            edit;
    logic             refresh;
  } time_t;

  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] m);
    logic [6:0] s;
    s = {1'b0, v} + 7'd1;
    if (s >= {1'b0, m}) begin
      return 6'd0;
    end
    return s[5:0];
  endfunction

  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] m);
    if (v == 6'd0 || v >= m) begin
      return m - 6'd1;
    end
    return v - 6'd1;
  endfunction

  function automatic logic [2:0] digit_tens(input logic [5:0] v);
    logic [2:0] t;
    priority if (v >= 6'd60) t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] digit_ones(input logic [5:0] v);
    logic [5:0] base;
    logic [5:0] rem;
    base = {3'b000, digit_tens(v)} * 6'd10;
    rem  = v - base;
    return rem[3:0];
  endfunction

endpackage

// ===== design/dcsm_core.sv =====
// Time and edit-mode state with its next-state logic.
// Depends on dcsm_pkg.
module dcsm_core import dcsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  cmd_t            cmd_i,
  input  logic [TpsW-1:0] tps_i,
  output time_t           nxt_o
);

  logic [TickW-1:0] tick_q, tick_d;
  logic [SecW-1:0]  sec_q, sec_d;
  logic [MinW-1:0]  min_q, min_d;
  logic [HourW-1:0] hour_q, hour_d;
  edit_e            edit_q, edit_d;
  logic             refresh;
  logic [TickW-1:0] tick_inc;
  logic [1:0]       edit_inc;
  logic [5:0]       hour_w;
  logic [5:0]       fld_w;

  always_comb begin
    tick_d   = tick_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    edit_d   = edit_q;
    refresh  = 1'b0;
    tick_inc = tick_q + 8'd1;
    edit_inc = edit_q + 2'd1;
    hour_w   = 6'd0;
    fld_w    = 6'd0;
    if (!cmd_i.command) begin
      // ticks count only while running
      if (edit_q == EditRun) begin
        if (tick_inc < tps_i) begin
          tick_d = tick_inc;
        end else begin
          tick_d  = '0;
          refresh = 1'b1;
          sec_d   = wrap_up(sec_q, SecMod);
          if (sec_d == 6'd0) begin
            min_d = wrap_up(min_q, MinMod);
            if (min_d == 6'd0) begin
              hour_w = wrap_up({1'b0, hour_q}, HourMod);
              hour_d = hour_w[HourW-1:0];
            end
          end
        end
      end
    end else begin
      refresh = 1'b1;
      if (cmd_i.btn_select) begin
        edit_d = edit_e'(edit_inc);
      end
      // up first, then down, on the field at the new position
      unique case (edit_d)
        EditHour: begin
          fld_w = {1'b0, hour_q};
          if (cmd_i.btn_up) fld_w = wrap_up(fld_w, HourMod);
          if (cmd_i.btn_dn) fld_w = wrap_down(fld_w, HourMod);
          hour_d = fld_w[HourW-1:0];
        end
        EditMin: begin
          fld_w = min_q;
          if (cmd_i.btn_up) fld_w = wrap_up(fld_w, MinMod);
          if (cmd_i.btn_dn) fld_w = wrap_down(fld_w, MinMod);
          min_d = fld_w;
        end
        EditSec: begin
          fld_w = sec_q;
          if (cmd_i.btn_up) fld_w = wrap_up(fld_w, SecMod);
          if (cmd_i.btn_dn) fld_w = wrap_down(fld_w, SecMod);
          sec_d = fld_w;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      edit_q <= EditRun;
    end else if (accept_i) begin
      tick_q <= tick_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      edit_q <= edit_d;
    end
  end

  assign nxt_o = '{hours: hour_d, minutes: min_d, seconds: sec_d,
                   edit: edit_d, refresh: refresh};

endmodule

// ===== design/dcsm_digits.sv =====
// Splits the updated time into decimal display digits.
// Depends on dcsm_pkg.
module dcsm_digits import dcsm_pkg::*; (
  input  time_t time_i,
  output disp_t disp_o
);

  logic [2:0] hour_tens_w;

  assign hour_tens_w = digit_tens({1'b0, time_i.hours});

  always_comb begin
    disp_o.hour_tens   = hour_tens_w[1:0];
    disp_o.hour_ones   = digit_ones({1'b0, time_i.hours});
    disp_o.minute_tens = digit_tens(time_i.minutes);
    disp_o.minute_ones = digit_ones(time_i.minutes);
    disp_o.second_tens = digit_tens(time_i.seconds);
    disp_o.second_ones = digit_ones(time_i.seconds);
    disp_o.edit_field  = time_i.edit;
    disp_o.refresh     = time_i.refresh;
  end

endmodule

// ===== design/dcsm_out_reg.sv =====
// Result register with valid/ready handshake toward the display side.
// Depends on dcsm_pkg.
module dcsm_out_reg import dcsm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  disp_t word_i,
  output logic  ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output disp_t out_word_o
);

  logic  valid_q;
  disp_t word_q;

  // free when empty or draining this cycle
  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== design/digital_clock_with_set_mode.sv =====
// Top level of the 24-hour clock with set mode: prescale register,
// counter core, digit split and result register. Depends on dcsm_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_word_i) carries one word per
//   event: a timer tick (command = 0) or a button event (command = 1) with
//   the select, up and down button levels.
//   Output channel (out_valid_o/out_ready_i/out_word_o) returns exactly
//   one word per accepted input word: six display digits, the edit
//   position and a redraw flag.
//   Config channel (cfg_valid_i/cfg_ready_o/cfg_wdata_i) writes the
//   ticks-per-second prescale; always ready, write it while idle.
// Result word: registered, valid in the cycle after the input is accepted.
// Throughput: one word per cycle unless the output stalls; the counter core
//   is combinational, so a word is taken in the cycle the previous result drains.
// Stall: while out_valid_o is high and out_ready_i low, in_ready_o drops,
//   the result word holds and the clock state does not advance.
// Reset: time 00:00:00, running mode, tick count cleared, prescale 5.
module digital_clock_with_set_mode import dcsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [TpsW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cmd_t            in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output disp_t           out_word_o
);

  logic [TpsW-1:0] tps_q;
  logic            accept;
  logic            stage_ready;
  time_t           nxt;
  disp_t           disp;

  // Prescale register; no stall on writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tps_q <= cfg_wdata_i;
    end
  end

  // Take a word whenever the result register can absorb it
  assign in_ready_o = stage_ready;
  assign accept     = in_valid_i && in_ready_o;

  // Advance time or apply buttons; state commits on accept
  dcsm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (in_word_i),
    .tps_i    (tps_q),
    .nxt_o    (nxt)
  );

  // Split the new time into display digits
  dcsm_digits u_digits (
    .time_i (nxt),
    .disp_o (disp)
  );

  // Hold the result word until the receiver takes it
  dcsm_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .word_i      (disp),
    .ready_o     (stage_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== design/dcsm_checker.sv =====
// Port-level checks for the digital clock block, bound to the top level.
// Depends on dcsm_pkg.
module dcsm_checker import dcsm_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input cmd_t  in_word_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input disp_t out_word_o
);

  // every accepted word shows up as a result next cycle
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // button events always request a redraw
  a_button_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.command |=> out_word_o.refresh)
    else $error("button event without refresh");

  // input backpressure only while a result is stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

endmodule

bind digital_clock_with_set_mode dcsm_checker u_dcsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

// ===== tb/tb.sv =====
// Self-checking bench for the 24-hour clock with set mode: directed stimulus table,
// prescale writes and random tick and button traffic, each result checked against a predictor.
// Depends on dcsm_pkg and digital_clock_with_set_mode.
module tb;
  import dcsm_pkg::*;

  localparam int DAY_HOURS      = 24;
  localparam int HOUR_MINUTES   = 60;
  localparam int MINUTE_SECONDS = 60;
  localparam int QUIET_LIMIT    = 1000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
  localparam int PHASE_WORDS    = 330;   // random words per traffic phase
  localparam int MAX_REPORTS    = 50;

  // Input words by name: timer tick, or a button event with its buttons
  localparam cmd_t TICK       = 4'b0000;
  localparam cmd_t BTN_NONE   = 4'b1000;
  localparam cmd_t BTN_SEL    = 4'b1100;
  localparam cmd_t BTN_UP     = 4'b1010;
  localparam cmd_t BTN_DN     = 4'b1001;
  localparam cmd_t BTN_SEL_UP = 4'b1110;
  localparam cmd_t BTN_SEL_DN = 4'b1101;
  localparam cmd_t BTN_UP_DN  = 4'b1011;
  localparam cmd_t BTN_ALL    = 4'b1111;

  typedef struct {
    cmd_t  word;
    bit    pinned;  // want holds a value read straight off the spec
    disp_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [TpsW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  cmd_t                in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  disp_t               out_word_o;

  // Predicted clock state, at the block's widths
  logic [TpsW-1:0]     prescale   = TpsReset;
  logic [TickW-1:0]    tick_cnt   = '0;
  logic [HourW-1:0]    hours      = '0;
  logic [MinW-1:0]     minutes    = '0;
  logic [SecW-1:0]     seconds    = '0;
  edit_e               edit_pos   = EditRun;

  disp_t               display_q[$];  // expected result words, oldest first
  dir_row_t            rows[$];

  // Pinned expectation travels with the word it belongs to
  bit                  pin_on     = 1'b0;
  disp_t               pin_want   = '0;

  edit_e               gen_pos    = EditRun;  // edit position as the stimulus side sees it
  int                  send_idle  = 0;
  int                  recv_idle  = 0;
  int                  stall_req  = 0;
  int                  stall_ack  = 0;
  int                  stall_left = 0;
  int                  quiet      = 0;

  int                  mismatches = 0;
  int                  words_in   = 0;
  int                  results_out = 0;
  int                  presses    = 0;
  int                  secs_adv   = 0;
  int                  tps_writes = 0;

  digital_clock_with_set_mode dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor helpers
  // ---------------------------------------------------------------------------

  function automatic int step_up(int v, int modulus);
    return (v + 1 >= modulus) ? 0 : v + 1;
  endfunction

  // Anything out of range steps down to the top value, same as zero does
  function automatic int step_down(int v, int modulus);
    return (v == 0 || v >= modulus) ? modulus - 1 : v - 1;
  endfunction

  // Split a time into the display word
  function automatic disp_t show(int h, int m, int s, edit_e e, bit redraw);
    disp_t d;
    d.hour_tens   = 2'(h / 10);
    d.hour_ones   = 4'(h % 10);
    d.minute_tens = 3'(m / 10);
    d.minute_ones = 4'(m % 10);
    d.second_tens = 3'(s / 10);
    d.second_ones = 4'(s % 10);
    d.edit_field  = e;
    d.refresh     = redraw;
    return d;
  endfunction

  // Step the field under edit; nothing happens while running
  task automatic nudge_field(input bit up);
    case (edit_pos)
      EditHour: begin
        hours = 5'(up ? step_up(int'(hours), DAY_HOURS) : step_down(int'(hours), DAY_HOURS));
      end
      EditMin: begin
        minutes = 6'(up ? step_up(int'(minutes), HOUR_MINUTES)
                        : step_down(int'(minutes), HOUR_MINUTES));
      end
      EditSec: begin
        seconds = 6'(up ? step_up(int'(seconds), MINUTE_SECONDS)
                        : step_down(int'(seconds), MINUTE_SECONDS));
      end
      default: ;
    endcase
  endtask

  // Apply one word to the predicted clock and return the display it leaves
  task automatic predict_display(input cmd_t w, output disp_t d);
    logic [TickW-1:0] nxt;
    bit               redraw;
    redraw = 1'b0;
    if (!w.command) begin
      // Ticks count only while running; the prescale compare uses the new count
      if (edit_pos == EditRun) begin
        nxt = tick_cnt + 8'd1;
        if (nxt < prescale) begin
          tick_cnt = nxt;
        end else begin
          tick_cnt = '0;
          redraw   = 1'b1;
          secs_adv++;
          seconds = 6'(step_up(int'(seconds), MINUTE_SECONDS));
          if (seconds == 0) begin
            minutes = 6'(step_up(int'(minutes), HOUR_MINUTES));
            if (minutes == 0) begin
              hours = 5'(step_up(int'(hours), DAY_HOURS));
            end
          end
        end
      end
    end else begin
      // Select first, then up, then down, all on the new position
      presses++;
      if (w.btn_select) begin
        edit_pos = edit_e'(edit_pos + 2'd1);
      end
      if (w.btn_up) begin
        nudge_field(1'b1);
      end
      if (w.btn_dn) begin
        nudge_field(1'b0);
      end
      redraw = 1'b1;
    end
    d = show(int'(hours), int'(minutes), int'(seconds), edit_pos, redraw);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH result %0d %s: got %0d, expected %0d", results_out, what, got, want);
    end
  endtask

  task automatic compare_word(input disp_t got, input disp_t want);
    if (got.hour_tens !== want.hour_tens) begin
      report_mismatch("hour_tens", int'(got.hour_tens), int'(want.hour_tens));
    end
    if (got.hour_ones !== want.hour_ones) begin
      report_mismatch("hour_ones", int'(got.hour_ones), int'(want.hour_ones));
    end
    if (got.minute_tens !== want.minute_tens) begin
      report_mismatch("minute_tens", int'(got.minute_tens), int'(want.minute_tens));
    end
    if (got.minute_ones !== want.minute_ones) begin
      report_mismatch("minute_ones", int'(got.minute_ones), int'(want.minute_ones));
    end
    if (got.second_tens !== want.second_tens) begin
      report_mismatch("second_tens", int'(got.second_tens), int'(want.second_tens));
    end
    if (got.second_ones !== want.second_ones) begin
      report_mismatch("second_ones", int'(got.second_ones), int'(want.second_ones));
    end
    if (got.edit_field !== want.edit_field) begin
      report_mismatch("edit_field", int'(got.edit_field), int'(want.edit_field));
    end
    if (got.refresh !== want.refresh) begin
      report_mismatch("refresh", int'(got.refresh), int'(want.refresh));
    end
  endtask

  // Watch every handshake at the edge. Retire the result first, then predict
  // the new word: the result register lies between them, so a result never
  // belongs to the word accepted at the same edge.
  always @(posedge clk_i) begin : watch
    disp_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        prescale = cfg_wdata_i;
        tps_writes++;
      end
      if (out_valid_o && out_ready_i) begin
        if (display_q.size() == 0) begin
          report_mismatch("arrived with nothing pending", int'(out_word_o), 0);
        end else begin
          want = display_q.pop_front();
          compare_word(out_word_o, want);
        end
        results_out++;
      end
      if (in_valid_i && in_ready_o) begin
        predict_display(in_word_i, want);
        // A pinned row overrides the predictor, which still tracks the state
        display_q.push_back(pin_on ? pin_want : want);
        words_in++;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here on request
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_req != stall_ack) begin
      stall_ack   <= stall_req;
      stall_left  <= HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: drop the run when nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("digital_clock_with_set_mode test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_row(input cmd_t w, input bit pin, input disp_t want);
    dir_row_t r;
    r.word   = w;
    r.pinned = pin;
    r.want   = want;
    rows.push_back(r);
  endtask

  // Offer one word, idling first at random, and hold it until taken
  task automatic send_word(input cmd_t w, input bit pin = 1'b0, input disp_t want = '0);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    pin_on     <= pin;
    pin_want   <= want;
    if (w.command && w.btn_select) begin
      gen_pos = edit_e'(gen_pos + 2'd1);
    end
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and wait until every expected word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (display_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the prescale; call only with the block idle
  task automatic write_tps(input logic [TpsW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic: mostly tick bursts and well-formed set sequences
  // (select into a field, step it, select back to running), some noise.
  task automatic run_phase(input int n_words);
    int   sent;
    int   pick;
    cmd_t w;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        repeat ($urandom_range(1, 20)) begin
          w = TICK;
          if ($urandom_range(9) == 0) begin
            w = cmd_t'({1'b1, 3'($urandom_range(7))});
          end
          send_word(w);
          sent++;
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 3)) begin
          send_word(cmd_t'({2'b11, 2'($urandom_range(3))}));
          sent++;
        end
        repeat ($urandom_range(1, 8)) begin
          send_word(cmd_t'({2'b10, 2'($urandom_range(3))}));
          sent++;
        end
        while (gen_pos != EditRun) begin
          send_word(cmd_t'({2'b11, 2'($urandom_range(3))}));
          sent++;
        end
      end else begin
        send_word(cmd_t'(4'($urandom_range(15))));
        sent++;
      end
    end
  endtask

  initial begin : main
    // Hold reset, then release it at an edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one idling: sender rarely, receiver often
    send_idle = 17;
    recv_idle <= 53;

    // Directed table, reset prescale of five ticks per second
    add_row(TICK,       1'b1, show(0, 0, 0, EditRun, 1'b0));
    add_row(TICK,       1'b0, '0);
    add_row(TICK,       1'b0, '0);
    add_row(TICK,       1'b1, show(0, 0, 0, EditRun, 1'b0));
    add_row(TICK,       1'b1, show(0, 0, 1, EditRun, 1'b1));    // fifth tick: one second
    add_row(BTN_NONE,   1'b1, show(0, 0, 1, EditRun, 1'b1));    // redraw even with no button
    add_row(BTN_UP,     1'b1, show(0, 0, 1, EditRun, 1'b1));    // up/down ignored while running
    add_row(BTN_DN,     1'b1, show(0, 0, 1, EditRun, 1'b1));
    add_row(BTN_SEL,    1'b1, show(0, 0, 1, EditHour, 1'b1));
    add_row(TICK,       1'b1, show(0, 0, 1, EditHour, 1'b0));   // tick dropped while editing
    add_row(BTN_DN,     1'b1, show(23, 0, 1, EditHour, 1'b1));  // hour wraps down
    add_row(BTN_UP,     1'b1, show(0, 0, 1, EditHour, 1'b1));   // and back up
    add_row(BTN_DN,     1'b0, '0);
    add_row(BTN_SEL_UP, 1'b1, show(23, 1, 1, EditMin, 1'b1));   // select then step new field
    add_row(BTN_DN,     1'b0, '0);
    add_row(BTN_DN,     1'b1, show(23, 59, 1, EditMin, 1'b1));
    add_row(BTN_UP_DN,  1'b1, show(23, 59, 1, EditMin, 1'b1));  // up, then down
    add_row(BTN_SEL_DN, 1'b1, show(23, 59, 0, EditSec, 1'b1));
    add_row(BTN_DN,     1'b1, show(23, 59, 59, EditSec, 1'b1));
    add_row(BTN_ALL,    1'b1, show(23, 59, 59, EditRun, 1'b1)); // back to running
    add_row(TICK,       1'b0, '0);
    add_row(TICK,       1'b0, '0);
    add_row(TICK,       1'b0, '0);
    add_row(TICK,       1'b0, '0);
    add_row(TICK,       1'b1, show(0, 0, 0, EditRun, 1'b1));    // full day wrap
    foreach (rows[i]) begin
      send_word(rows[i].word, rows[i].pinned, rows[i].want);
    end
    drain();

    // Prescale extremes: zero advances on every tick, 255 barely moves
    write_tps(8'd0);
    repeat (3) send_word(TICK);
    drain();
    write_tps(8'd255);
    repeat (100) send_word(TICK);
    drain();
    // Drop the prescale below the held count: the next tick must advance
    write_tps(8'd2);
    repeat (3) send_word(TICK);
    drain();

    write_tps(8'd1);
    run_phase(PHASE_WORDS);
    drain();

    // Phase two: swap the idling sides
    send_idle = 53;
    recv_idle <= 17;
    write_tps(8'($urandom_range(2, 6)));
    run_phase(PHASE_WORDS);
    drain();

    // Phase three: no idling, but one long receiver hold-off while the
    // sender keeps offering, so the block fills and stalls its input
    send_idle = 0;
    recv_idle <= 0;
    write_tps(8'($urandom_range(0, 3)));
    stall_req <= stall_req + 1;
    run_phase(PHASE_WORDS);
    drain();
    repeat (4) @(posedge clk_i);

    $display("covered %0d words (%0d button events, %0d seconds advanced), %0d results",
             words_in, presses, secs_adv, results_out);
    $display("over %0d prescale writes from 0 to 255; %0d mismatches", tps_writes, mismatches);
    if (mismatches == 0) begin
      $display("digital_clock_with_set_mode test passed");
    end else begin
      $display("digital_clock_with_set_mode test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dcsm_pkg.sv
design/dcsm_core.sv
design/dcsm_digits.sv
design/dcsm_out_reg.sv
design/digital_clock_with_set_mode.sv
design/dcsm_checker.sv
tb/tb.sv
